// File: hw/rtl/kdr_pkg.sv
// ----------------------------------------------------------------------------
// kdr_pkg
// Types and constants shared by the key debounce and auto-repeat block.
// ----------------------------------------------------------------------------
package kdr_pkg;

    localparam int PORT_WIDTH = 16;
    localparam int WORD_W     = 16;
    localparam int CD_W       = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [WORD_W-1:0] PORT_MASK = WORD_W'((64'd1 << PORT_WIDTH) - 64'd1);

    localparam logic [CD_W-1:0] DEBOUNCE_TICKS = CD_W'(5);
    localparam logic [CD_W-1:0] SETTLE_TICKS   = CD_W'(3);
    localparam logic [CD_W-1:0] DEFAULT_PERIOD = CD_W'(20);
    localparam logic [CD_W-1:0] DEFAULT_DELAY  = CD_W'(150);

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [CD_W-1:0]      count_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIN_SEL       = 2'd0,
        REG_REPEAT_PERIOD = 2'd1,
        REG_REPEAT_DELAY  = 2'd2
    } reg_idx_t;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_DEBOUNCE    = 3'd1,
        PH_GO_REPEAT   = 3'd2,
        PH_WAIT_REPEAT = 3'd3,
        PH_REPEAT      = 3'd4
    } phase_t;

    // effective settings, defaults already substituted
    typedef struct packed {
        word_t  pin_sel;
        count_t period;
        count_t delay;
    } kdr_cfg_t;

    typedef struct packed {
        logic  op;
        word_t port_word;
    } item_t;

endpackage

// File: hw/rtl/kdr_if.sv
// ----------------------------------------------------------------------------
// kdr channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface kdr_item_if;
    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [15:0]          port_word;

    modport source (output valid, output op, output port_word, input ready);
    modport sink   (input valid, input op, input port_word, output ready);
endinterface

interface kdr_result_if;
    logic valid;
    logic ready;
    logic press_event;
    logic repeat_event;

    modport source (output valid, output press_event, output repeat_event, input ready);
    modport sink   (input valid, input press_event, input repeat_event, output ready);
endinterface

interface kdr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/kdr_cfg_regs.sv
// ----------------------------------------------------------------------------
// kdr_cfg_regs
// Register file for key mask, repeat period and repeat delay.
// ----------------------------------------------------------------------------
module kdr_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    kdr_cfg_if.sink           cfg,
    output kdr_pkg::kdr_cfg_t cfg_out
);
    import kdr_pkg::*;

    word_t mask_reg;
    word_t period_reg;
    word_t delay_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= WORD_W'(1);
            period_reg <= '0;
            delay_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_PIN_SEL:       mask_reg   <= cfg.data;
                REG_REPEAT_PERIOD: period_reg <= cfg.data;
                REG_REPEAT_DELAY:  delay_reg  <= cfg.data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        cfg_out.pin_sel = mask_reg & PORT_MASK;
        cfg_out.period  = (period_reg == '0) ? DEFAULT_PERIOD : period_reg;
        cfg_out.delay   = (delay_reg == '0) ? DEFAULT_DELAY : delay_reg;
    end

endmodule

// File: hw/rtl/kdr_in_stage.sv
// ----------------------------------------------------------------------------
// kdr_in_stage
// Input register stage; holds one beat until the phase stage takes it.
// ----------------------------------------------------------------------------
module kdr_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    kdr_item_if.sink       item,
    input  logic           advance,
    output logic           held_valid,
    output kdr_pkg::item_t held_item
);
    import kdr_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign item.ready = !valid_reg || advance;
    assign valid_next = (item.valid && item.ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg.op        <= item.op;
            item_reg.port_word <= item.port_word;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// File: hw/rtl/kdr_phase_ctrl.sv
// ----------------------------------------------------------------------------
// kdr_phase_ctrl
// Phase machine, shared countdown and registered result beat.
// ----------------------------------------------------------------------------
module kdr_phase_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  kdr_pkg::kdr_cfg_t cfg_in,
    input  logic              held_valid,
    input  kdr_pkg::item_t    held_item,
    output logic              advance,
    kdr_result_if.source      result
);
    import kdr_pkg::*;

    phase_t phase_reg;
    phase_t phase_next;
    count_t cd_reg;
    count_t cd_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   press_reg;
    logic   repeat_reg;
    logic   press_next;
    logic   repeat_next;
    logic   pressed;
    logic   cd_zero;
    logic   sample;

    assign advance = held_valid && (!out_valid_reg || result.ready);
    assign pressed = (held_item.port_word & cfg_in.pin_sel) == '0;
    assign cd_zero = (cd_reg == '0);
    assign sample  = (held_item.op == OP_SAMPLE);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        cd_next    = cd_reg;
        if (!sample)
        begin
            if (!cd_zero)
                cd_next = cd_reg - CD_W'(1);
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (pressed)
                    begin
                        phase_next = PH_DEBOUNCE;
                        cd_next    = DEBOUNCE_TICKS;
                    end
                end
                PH_DEBOUNCE:
                begin
                    if (pressed && cd_zero)
                    begin
                        phase_next = PH_GO_REPEAT;
                        cd_next    = SETTLE_TICKS;
                    end
                end
                PH_GO_REPEAT:
                begin
                    if (!pressed)
                        phase_next = PH_IDLE;
                    else if (cd_zero)
                    begin
                        phase_next = PH_WAIT_REPEAT;
                        cd_next    = cfg_in.delay;
                    end
                end
                PH_WAIT_REPEAT:
                begin
                    if (!pressed)
                        phase_next = PH_IDLE;
                    else if (cd_zero)
                        phase_next = PH_REPEAT;
                end
                PH_REPEAT:
                begin
                    if (!pressed)
                        phase_next = PH_IDLE;
                    else if (cd_zero)
                        cd_next = cfg_in.period;
                end
                default:
                begin
                    if (!pressed)
                        phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // outputs
    always_comb
    begin
        press_next  = 1'b0;
        repeat_next = 1'b0;
        if (sample)
        begin
            case (phase_reg)
                PH_GO_REPEAT,
                PH_WAIT_REPEAT: press_next  = !pressed;
                PH_REPEAT:      repeat_next = pressed && cd_zero;
                default:        ;
            endcase
        end
    end

    assign out_valid_next = advance || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            cd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                phase_reg <= phase_next;
                cd_reg    <= cd_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            press_reg  <= press_next;
            repeat_reg <= repeat_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.press_event  = press_reg;
    assign result.repeat_event = repeat_reg;

endmodule

// File: hw/rtl/key_debounce_with_repeat_top.sv
// ----------------------------------------------------------------------------
// key_debounce_with_repeat_top
// Key debouncer with auto-repeat, driven by tick and sample beats.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the result is not stalled, and returns one
// result beat per input beat. The accepting edge writes the beat into the
// input register; the phase and countdown update is worked out from the held
// beat and written, together with the result, into the result register as
// soon as no earlier result is still stalled there. Since the state is updated
// as each beat leaves the input register, beats may arrive back to back; input
// ready drops only while both registers hold beats and the result is stalled.
// Register writes are taken at any time and should be made while idle.
module key_debounce_with_repeat_top (
    input  logic          clk,
    input  logic          rst_n,
    kdr_item_if.sink      item,
    kdr_result_if.source  result,
    kdr_cfg_if.sink       cfg
);
    import kdr_pkg::*;

    kdr_cfg_t cfg_eff;
    logic     held_valid;
    item_t    held_item;
    logic     advance;

    kdr_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_eff)
    );

    kdr_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    kdr_phase_ctrl u_phase (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_in     (cfg_eff),
        .held_valid (held_valid),
        .held_item  (held_item),
        .advance    (advance),
        .result     (result)
    );

endmodule

// File: hw/rtl/kdr_checker.sv
// ----------------------------------------------------------------------------
// kdr_checker
// Port-level checks for the key debouncer, bound to the top level.
// ----------------------------------------------------------------------------
module kdr_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic press_event,
    input logic repeat_event,
    input logic cfg_ready
);

    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(press_event && repeat_event))
        else $error("press and repeat flagged in one beat");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled while result side free");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !out_valid) |=> ##1 out_valid)
        else $error("accepted beat did not reach result");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(press_event)
                                       && $stable(repeat_event)))
        else $error("stalled result beat changed");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("register port not ready");

endmodule

bind key_debounce_with_repeat_top kdr_checker u_kdr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (item.valid),
    .in_ready     (item.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .press_event  (result.press_event),
    .repeat_event (result.repeat_event),
    .cfg_ready    (cfg.ready)
);

// File: sim/key_debounce_with_repeat_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_debounce_with_repeat_top_tb
// Self-checking bench for the key debouncer with auto-repeat. A short table of
// directed beats walks the phases once. Randomised press, hold and release
// sequences follow under several register settings and flow-control mixes.
// Every result beat is checked against fixed values for marked directed rows,
// else against an in-bench model of the phase and countdown logic.
// ----------------------------------------------------------------------------
module key_debounce_with_repeat_top_tb;
    import kdr_pkg::*;

    typedef struct packed {
        logic press;
        logic rep;
    } key_event_t;

    typedef struct {
        op_t        op;
        word_t      word;
        logic       known;
        key_event_t ev;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    kdr_item_if   item_ch ();
    kdr_result_if result_ch ();
    kdr_cfg_if    cfg_ch ();

    key_debounce_with_repeat_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // model state and register copies
    phase_t kp_phase;
    count_t kp_count;
    word_t  cfg_mask;
    count_t cfg_period;
    count_t cfg_delay;

    key_event_t pending_events [$];
    int         mismatches;
    int         items_sent;
    int         send_idle_pct;
    int         recv_stall_pct;

    stim_row_t directed_rows [30];

    function automatic key_event_t step_key(op_t op, word_t w);
        key_event_t ev;
        logic       pressed;
        count_t     per;
        count_t     dly;
        ev = '0;
        if (op == OP_TICK)
        begin
            if (kp_count != '0)
                kp_count = kp_count - 1'b1;
        end
        else
        begin
            pressed = ((w & cfg_mask & PORT_MASK) == '0);
            per     = (cfg_period != '0) ? cfg_period : DEFAULT_PERIOD;
            dly     = (cfg_delay != '0) ? cfg_delay : DEFAULT_DELAY;
            if (pressed && kp_phase == PH_IDLE)
            begin
                kp_phase = PH_DEBOUNCE;
                kp_count = DEBOUNCE_TICKS;
            end
            else if (kp_phase != PH_IDLE)
            begin
                if (pressed && kp_phase == PH_DEBOUNCE && kp_count == '0)
                begin
                    kp_phase = PH_GO_REPEAT;
                    kp_count = SETTLE_TICKS;
                end
                else if (!pressed && (kp_phase == PH_GO_REPEAT ||
                                      kp_phase == PH_WAIT_REPEAT))
                begin
                    ev.press = 1'b1;
                    kp_phase = PH_IDLE;
                end
                else if (pressed && kp_phase == PH_GO_REPEAT && kp_count == '0)
                begin
                    kp_phase = PH_WAIT_REPEAT;
                    kp_count = dly;
                end
                else if (pressed && kp_phase == PH_WAIT_REPEAT && kp_count == '0)
                begin
                    kp_phase = PH_REPEAT;
                end
                else if (pressed && kp_phase == PH_REPEAT && kp_count == '0)
                begin
                    kp_count = per;
                    ev.rep   = 1'b1;
                end
            end
            if (kp_phase >= PH_WAIT_REPEAT && !pressed)
                kp_phase = PH_IDLE;
        end
        return ev;
    endfunction

    function automatic word_t pressed_word();
        return word_t'($urandom) & ~cfg_mask;
    endfunction

    function automatic word_t released_word();
        word_t w;
        w = word_t'($urandom);
        if ((w & cfg_mask) == '0)
            w = w | cfg_mask;
        return w;
    endfunction

    task automatic issue_item(op_t op, word_t w, logic fixed, key_event_t fixed_ev);
        int         gap;
        key_event_t ev;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.op        <= op;
        item_ch.port_word <= w;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        ev = step_key(op, w);
        pending_events.push_back(fixed ? fixed_ev : ev);
        items_sent++;
    endtask

    task automatic write_reg(reg_idx_t idx, word_t d);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= d;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_PIN_SEL:       cfg_mask   = d;
            REG_REPEAT_PERIOD: cfg_period = d;
            REG_REPEAT_DELAY:  cfg_delay  = d;
            default: ;
        endcase
    endtask

    task automatic program_regs(word_t mask, word_t per, word_t dly);
        write_reg(REG_PIN_SEL, mask);
        write_reg(REG_REPEAT_PERIOD, per);
        write_reg(REG_REPEAT_DELAY, dly);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_traffic(int target);
        int     start;
        int     span;
        int     hold;
        int     r;
        count_t per;
        count_t dly;
        start = items_sent;
        while (items_sent - start < target)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 12))
                    issue_item(op_t'($urandom_range(0, 1)), word_t'($urandom), 1'b0, '0);
            end
            else
            begin
                per  = (cfg_period != '0) ? cfg_period : DEFAULT_PERIOD;
                dly  = (cfg_delay != '0) ? cfg_delay : DEFAULT_DELAY;
                span = 8 + int'(dly) + 3 * int'(per);
                if (span > 300)
                    span = 60;
                hold = $urandom_range(0, span * 10 / 7);
                issue_item(OP_SAMPLE, pressed_word(), 1'b0, '0);
                repeat (hold)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        issue_item(OP_TICK, word_t'($urandom), 1'b0, '0);
                    else if (r < 97)
                        issue_item(OP_SAMPLE, pressed_word(), 1'b0, '0);
                    else
                        issue_item(OP_SAMPLE, released_word(), 1'b0, '0);
                end
                issue_item(OP_SAMPLE, released_word(), 1'b0, '0);
            end
        end
    endtask

    always @(posedge clk)
        result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        key_event_t exp_ev;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_events.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: press %b repeat %b",
                             result_ch.press_event, result_ch.repeat_event);
            end
            else
            begin
                exp_ev = pending_events.pop_front();
                if (result_ch.press_event !== exp_ev.press ||
                    result_ch.repeat_event !== exp_ev.rep)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: press exp %b got %b, repeat exp %b got %b",
                                 exp_ev.press, result_ch.press_event,
                                 exp_ev.rep, result_ch.repeat_event);
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int i;
        int p;
        word_t mask_set [8];
        word_t per_set [8];
        word_t dly_set [8];

        rst_n             = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.op        = OP_TICK;
        item_ch.port_word = '0;
        result_ch.ready   = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_PIN_SEL;
        cfg_ch.data       = '0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        mismatches        = 0;
        items_sent        = 0;
        kp_phase          = PH_IDLE;
        kp_count          = '0;
        cfg_mask          = 16'h0001;
        cfg_period        = '0;
        cfg_delay         = '0;

        // walk through debounce, press, wait and repeat with short timings
        directed_rows = '{
            '{OP_TICK,   16'h0000, 1'b1, 2'b00},
            '{OP_SAMPLE, 16'hFFFF, 1'b1, 2'b00},
            '{OP_SAMPLE, 16'hFFFE, 1'b1, 2'b00},
            '{OP_SAMPLE, 16'hFFFF, 1'b1, 2'b00},
            '{OP_SAMPLE, 16'h0000, 1'b0, 2'b00},
            '{OP_TICK,   16'hFFFF, 1'b0, 2'b00},
            '{OP_TICK,   16'hA5A5, 1'b0, 2'b00},
            '{OP_TICK,   16'h5A5A, 1'b0, 2'b00},
            '{OP_TICK,   16'h8001, 1'b0, 2'b00},
            '{OP_TICK,   16'h7FFE, 1'b0, 2'b00},
            '{OP_SAMPLE, 16'hFFFE, 1'b0, 2'b00},
            '{OP_SAMPLE, 16'h0001, 1'b1, 2'b10},
            '{OP_SAMPLE, 16'h0000, 1'b0, 2'b00},
            '{OP_TICK,   16'h0000, 1'b0, 2'b00},
            '{OP_TICK,   16'h0000, 1'b0, 2'b00},
            '{OP_TICK,   16'h0000, 1'b0, 2'b00},
            '{OP_TICK,   16'h0000, 1'b0, 2'b00},
            '{OP_TICK,   16'h0000, 1'b0, 2'b00},
            '{OP_SAMPLE, 16'h0000, 1'b0, 2'b00},
            '{OP_SAMPLE, 16'h0000, 1'b0, 2'b00},
            '{OP_TICK,   16'h0000, 1'b0, 2'b00},
            '{OP_TICK,   16'h0000, 1'b0, 2'b00},
            '{OP_TICK,   16'h0000, 1'b0, 2'b00},
            '{OP_SAMPLE, 16'h0000, 1'b0, 2'b00},
            '{OP_TICK,   16'h0000, 1'b0, 2'b00},
            '{OP_SAMPLE, 16'h0000, 1'b0, 2'b00},
            '{OP_SAMPLE, 16'h0000, 1'b1, 2'b01},
            '{OP_TICK,   16'h0000, 1'b0, 2'b00},
            '{OP_SAMPLE, 16'h0000, 1'b0, 2'b00},
            '{OP_SAMPLE, 16'hFFFF, 1'b1, 2'b00}
        };

        mask_set = '{16'h0001, 16'hFFFF, 16'h0000, 16'h8000,
                     16'h00F0, word_t'($urandom), word_t'($urandom), word_t'($urandom)};
        per_set  = '{16'h0000, 16'h0001, 16'hFFFF, 16'h0003,
                     16'h0000, word_t'($urandom_range(0, 6)),
                     word_t'($urandom_range(0, 6)), word_t'($urandom_range(0, 6))};
        dly_set  = '{16'h0000, 16'h0001, 16'h0002, 16'hFFFF,
                     16'h0005, word_t'($urandom_range(0, 10)),
                     word_t'($urandom_range(0, 10)), word_t'($urandom_range(0, 10))};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        program_regs(16'h0001, 16'h0001, 16'h0001);
        for (i = 0; i < 30; i++)
            issue_item(directed_rows[i].op, directed_rows[i].word,
                       directed_rows[i].known, directed_rows[i].ev);

        for (p = 0; p < 8; p++)
        begin
            drain();
            program_regs(mask_set[p], per_set[p], dly_set[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            run_traffic(175);
        end

        item_ch.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0 && pending_events.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: key_debounce_with_repeat_top.f
hw/rtl/kdr_pkg.sv
hw/rtl/kdr_if.sv
hw/rtl/kdr_cfg_regs.sv
hw/rtl/kdr_in_stage.sv
hw/rtl/kdr_phase_ctrl.sv
hw/rtl/key_debounce_with_repeat_top.sv
hw/rtl/kdr_checker.sv
sim/key_debounce_with_repeat_top_tb.sv
